// File: rtl/core/fbba_pkg.sv
// Shared types and constants for the free block bitmap allocator.
`timescale 1ns / 1ps

package fbba_pkg;

    localparam int OP_W    = 2;
    localparam int ADDR_W  = 9;
    localparam int COUNT_W = 7;
    localparam int BYTE_W  = 8;

    // Map byte after reset: all blocks free; block 0 is taken out of byte 0
    localparam logic [BYTE_W-1:0] RESET_BYTE  = 8'hFF;
    localparam logic [BYTE_W-1:0] BLOCK0_MASK = 8'h01;

    typedef enum logic [OP_W-1:0] {
        OP_SEARCH_FREE = 2'd0,
        OP_MARK_USED   = 2'd1,
        OP_MARK_FREE   = 2'd2,
        OP_SEARCH_RUN  = 2'd3
    } op_t;

    // Source of the block address in a result word
    typedef enum logic [1:0] {
        OSEL_FREE = 2'd0,
        OSEL_RUN  = 2'd1,
        OSEL_MARK = 2'd2,
        OSEL_FAIL = 2'd3
    } osel_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_MARK_BAD,
        ST_FREE_RD,
        ST_FREE_LD,
        ST_FREE_EMIT,
        ST_RUN_RD,
        ST_RUN_EVAL,
        ST_FAIL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic  req_load;
        logic  ptr_clr;
        logic  ptr_start;
        logic  ptr_inc;
        logic  rd_en;
        logic  clr_wr;
        logic  mark_wr;
        logic  bits_load;
        logic  run_update;
        logic  emit;
        osel_t osel;
        logic  found;
        logic  last;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic addr_ok;
        logic count_ok;
        logic ptr_last;
        logic bits_any;
        logic free_last;
        logic run_hit;
        logic out_free;
    } stat_t;

endpackage

// File: rtl/core/fbba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fbba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/fbba_ctrl.sv
// Sequencer for the allocator: clearing pass, request dispatch and map scans.
`timescale 1ns / 1ps

module fbba_ctrl import fbba_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.osel   = OSEL_FAIL;
        s_tready   = 1'b0;

        unique case (state_reg)
            // Write the reset image, one byte a cycle
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.ptr_last)
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.req_load = 1'b1;
                    state_next   = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                unique case (stat.op)
                    OP_MARK_USED, OP_MARK_FREE:
                    begin
                        cmd.ptr_start = 1'b1;
                        state_next    = stat.addr_ok ? ST_MARK_RD : ST_MARK_BAD;
                    end
                    OP_SEARCH_FREE:
                    begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = stat.count_ok ? ST_FREE_RD : ST_FAIL;
                    end
                    OP_SEARCH_RUN:
                    begin
                        cmd.ptr_start = 1'b1;
                        state_next    = (stat.count_ok && stat.addr_ok) ? ST_RUN_RD : ST_FAIL;
                    end
                    default:
                    begin
                        state_next = ST_FAIL;
                    end
                endcase
            end

            // Read-modify-write of one map byte
            ST_MARK_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_MARK_WR;
            end

            ST_MARK_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.mark_wr = 1'b1;
                    cmd.emit    = 1'b1;
                    cmd.osel    = OSEL_MARK;
                    cmd.found   = 1'b1;
                    cmd.last    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_MARK_BAD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.osel   = OSEL_MARK;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            // First-free scan: load a byte, then report its free bits low to high
            ST_FREE_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_FREE_LD;
            end

            ST_FREE_LD:
            begin
                cmd.bits_load = 1'b1;
                state_next    = ST_FREE_EMIT;
            end

            ST_FREE_EMIT:
            begin
                if (stat.bits_any)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit  = 1'b1;
                        cmd.osel  = OSEL_FREE;
                        cmd.found = 1'b1;
                        cmd.last  = stat.free_last;
                        if (stat.free_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (stat.ptr_last)
                begin
                    state_next = ST_FAIL;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = ST_FREE_RD;
                end
            end

            // Run scan: eight bits per byte read
            ST_RUN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RUN_EVAL;
            end

            ST_RUN_EVAL:
            begin
                if (stat.run_hit)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        cmd.osel   = OSEL_RUN;
                        cmd.found  = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.run_update = 1'b1;
                    if (stat.ptr_last)
                    begin
                        state_next = ST_FAIL;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = ST_RUN_RD;
                    end
                end
            end

            ST_FAIL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.osel   = OSEL_FAIL;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/fbba_dpath.sv
// Allocator datapath: map RAM, request registers, scan logic, result register.
`timescale 1ns / 1ps

module fbba_dpath import fbba_pkg::*; #(
    parameter int MAP_BYTES   = 64,
    parameter int MAX_REQUEST = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tuser,
    output logic        m_tlast,
    input  cmd_t        cmd,
    output stat_t       stat
);

    localparam int IDX_W      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int NUM_BLOCKS = MAP_BYTES * 8;
    localparam logic [IDX_W-1:0]   LAST_BYTE = IDX_W'(MAP_BYTES - 1);
    localparam logic [COUNT_W-1:0] MAX_REQ_C = COUNT_W'(MAX_REQUEST);

    // Request registers
    op_t                op_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COUNT_W-1:0] count_reg;

    // Scan state
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [BYTE_W-1:0]  bits_reg, bits_next;
    logic [COUNT_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic [ADDR_W-1:0]  start_reg, start_next;
    logic               first_reg, first_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]  bout_reg, bout_next;
    logic               found_reg, found_next;
    logic               last_reg, last_next;

    logic [BYTE_W-1:0]  rd_data;
    logic [BYTE_W-1:0]  wr_data;
    logic [BYTE_W-1:0]  bit_mask;
    logic [IDX_W+5:0]   addr_byte_ext;
    logic [2:0]         low_idx;
    logic [IDX_W+11:0]  free_addr_ext;
    logic [COUNT_W-1:0] run_v;
    logic [ADDR_W-1:0]  start_v;
    logic [ADDR_W-1:0]  hit_start;
    logic               hit;
    logic [IDX_W+11:0]  bit_addr_ext;

    fbba_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAP_BYTES),
        .AW    (IDX_W)
    ) u_map (
        .clk     (clk),
        .wr_en   (cmd.clr_wr || cmd.mark_wr),
        .wr_addr (ptr_reg),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // Write data: reset image while clearing, else the marked byte
    assign bit_mask = BLOCK0_MASK << addr_reg[2:0];
    always_comb
    begin
        if (cmd.clr_wr)
        begin
            wr_data = (ptr_reg == '0) ? (RESET_BYTE & ~BLOCK0_MASK) : RESET_BYTE;
        end
        else if (op_reg == OP_MARK_USED)
        begin
            wr_data = rd_data & ~bit_mask;
        end
        else
        begin
            wr_data = rd_data | bit_mask;
        end
    end

    // Lowest free bit of the byte under report
    always_comb
    begin
        low_idx = 3'd0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (bits_reg[i])
            begin
                low_idx = 3'(i);
            end
        end
    end
    assign free_addr_ext = {9'd0, ptr_reg, low_idx};

    // Run tracking across the eight bits of the byte just read
    always_comb
    begin
        run_v        = run_reg;
        start_v      = start_reg;
        hit          = 1'b0;
        hit_start    = start_reg;
        bit_addr_ext = '0;
        for (int i = 0; i < BYTE_W; i++)
        begin
            bit_addr_ext = {9'd0, ptr_reg, 3'(i)};
            if (!hit && !(first_reg && (3'(i) < addr_reg[2:0])))
            begin
                if (rd_data[i])
                begin
                    if (run_v == '0)
                    begin
                        start_v = bit_addr_ext[ADDR_W-1:0];
                    end
                    run_v = run_v + 1'b1;
                    if (run_v == count_reg)
                    begin
                        hit       = 1'b1;
                        hit_start = start_v;
                    end
                end
                else
                begin
                    run_v = '0;
                end
            end
        end
    end

    assign addr_byte_ext = {{IDX_W{1'b0}}, addr_reg[ADDR_W-1:3]};

    // Next state of the scan registers
    always_comb
    begin
        ptr_next      = ptr_reg;
        bits_next     = bits_reg;
        emit_cnt_next = emit_cnt_reg;
        run_next      = run_reg;
        start_next    = start_reg;
        first_next    = first_reg;

        priority if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_start)
        begin
            ptr_next = addr_byte_ext[IDX_W-1:0];
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.req_load)
        begin
            emit_cnt_next = '0;
            run_next      = '0;
            start_next    = '0;
            first_next    = 1'b1;
        end

        if (cmd.bits_load)
        begin
            bits_next = rd_data;
        end
        else if (cmd.emit && cmd.osel == OSEL_FREE)
        begin
            bits_next     = bits_reg & (bits_reg - 1'b1);
            emit_cnt_next = emit_cnt_reg + 1'b1;
        end

        if (cmd.run_update)
        begin
            run_next   = run_v;
            start_next = start_v;
            first_next = 1'b0;
        end
    end

    // Result register: loaded on emit, emptied when taken
    assign stat.out_free = !out_valid_reg || m_tready;
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        bout_next      = bout_reg;
        found_next     = found_reg;
        last_next      = last_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            found_next     = cmd.found;
            last_next      = cmd.last;
            unique case (cmd.osel)
                OSEL_FREE: bout_next = free_addr_ext[ADDR_W-1:0];
                OSEL_RUN:  bout_next = hit_start;
                OSEL_MARK: bout_next = addr_reg;
                OSEL_FAIL: bout_next = '0;
                default:   bout_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            emit_cnt_reg  <= '0;
            run_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            emit_cnt_reg  <= emit_cnt_next;
            run_reg       <= run_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.req_load)
        begin
            op_reg    <= op_t'(s_tuser);
            addr_reg  <= s_tdata[ADDR_W-1:0];
            count_reg <= s_tdata[ADDR_W+COUNT_W-1:ADDR_W];
        end
        bits_reg  <= bits_next;
        start_reg <= start_next;
        bout_reg  <= bout_next;
        found_reg <= found_next;
        last_reg  <= last_next;
    end

    // Status back to the controller
    assign stat.op        = op_reg;
    assign stat.addr_ok   = int'({23'd0, addr_reg}) < NUM_BLOCKS;
    assign stat.count_ok  = (count_reg != '0) && (count_reg <= MAX_REQ_C);
    assign stat.ptr_last  = (ptr_reg == LAST_BYTE);
    assign stat.bits_any  = (bits_reg != '0);
    assign stat.free_last = ((emit_cnt_reg + 1'b1) == count_reg);
    assign stat.run_hit   = hit;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16 - ADDR_W){1'b0}}, bout_reg};
    assign m_tuser  = found_reg;
    assign m_tlast  = last_reg;

`ifndef NO_ASSERTIONS
    // A new word never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    // A free-block report always has a free bit to report
    a_free_has_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.osel == OSEL_FREE) |-> (bits_reg != '0))
        else $error("free report with empty byte");

    // Never more free-block reports than requested
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.osel == OSEL_FREE) |-> (emit_cnt_reg < count_reg))
        else $error("free search over-reported");

    // Clearing and marking never share the write port
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !cmd.mark_wr && !cmd.emit)
        else $error("map write conflict");
`endif

endmodule

// File: rtl/core/free_block_bitmap_allocator.sv
// Free block bitmap allocator: top level joining controller and datapath.
//
// Keeps one bit per block (set = free) in a MAP_BYTES-byte RAM and serves one request at
// a time: search free, mark used, mark free, search run. After reset the block runs a
// clearing pass, with s_tready low, that leaves every block free except block 0. A mark
// reads the map byte and writes it back. A first-free search reads the map from byte 0
// and reports free blocks in address order; a run search reads from the start byte; both
// stop early once satisfied. Results leave through a one-word output register, so the
// next request is taken while the last result still waits.
`timescale 1ns / 1ps

module free_block_bitmap_allocator import fbba_pkg::*; #(
    parameter int MAP_BYTES   = 64,
    parameter int MAX_REQUEST = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] address, [15:9] count
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [8:0] block_address, [15:9] zero
    output logic        m_tuser,   // [0] found
    output logic        m_tlast
);

    cmd_t  cmd;
    stat_t stat;

    fbba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbba_dpath #(
        .MAP_BYTES   (MAP_BYTES),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the free block bitmap allocator.
`timescale 1ns / 1ps

module testbench;
    import fbba_pkg::*;

    localparam int MAP_BYTES   = 64;
    localparam int MAX_REQUEST = 64;
    localparam int NUM_BLOCKS  = MAP_BYTES * 8;
    localparam int DRAIN_WAIT  = 3 * MAP_BYTES + MAX_REQUEST + 64;
    localparam int N_DIRECTED  = 25;

    // One result word: block address, found flag, last flag
    typedef struct packed {
        logic [ADDR_W-1:0] blk;
        logic              found;
        logic              last;
    } grant_t;

    // One row of the directed table; hand_chk marks a typed single result
    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] cnt;
        logic               hand_chk;
        logic [ADDR_W-1:0]  exp_blk;
        logic               exp_found;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [8:0] address, [15:9] count
    logic [1:0]  s_tuser = '0;   // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [8:0] block_address, [15:9] zero
    logic        m_tuser;        // [0] found
    logic        m_tlast;

    // Shadow copy of the free map, set bit = free block
    logic        free_bits [NUM_BLOCKS];
    grant_t      expected_grants [$];
    int          fail_count = 0;
    int          burst_left = 0;
    plan_row_t   plan [N_DIRECTED];

    free_block_bitmap_allocator #(
        .MAP_BYTES   (MAP_BYTES),
        .MAX_REQUEST (MAX_REQUEST)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic grant_t make_grant(input int blk, input logic found, input logic last);
        grant_t g;
        g.blk   = blk[ADDR_W-1:0];
        g.found = found;
        g.last  = last;
        return g;
    endfunction

    // Work out the result words of one request and update the shadow map
    function automatic void predict_allocation(input op_t op, input logic [ADDR_W-1:0] addr,
                                               input logic [COUNT_W-1:0] cnt);
        int  hits;
        int  run_len;
        int  run_start;
        bit  run_found;
        hits      = 0;
        run_len   = 0;
        run_start = 0;
        run_found = 1'b0;
        if (op == OP_MARK_USED || op == OP_MARK_FREE)
        begin
            if (int'(addr) >= NUM_BLOCKS)
                expected_grants.push_back(make_grant(int'(addr), 1'b0, 1'b1));
            else
            begin
                free_bits[addr] = (op == OP_MARK_FREE);
                expected_grants.push_back(make_grant(int'(addr), 1'b1, 1'b1));
            end
        end
        else if (cnt == '0 || int'(cnt) > MAX_REQUEST)
            expected_grants.push_back(make_grant(0, 1'b0, 1'b1));
        else if (op == OP_SEARCH_FREE)
        begin
            // first cnt free blocks in address order, fail word if short
            for (int b = 0; b < NUM_BLOCKS && hits < int'(cnt); b++)
            begin
                if (free_bits[b])
                begin
                    hits++;
                    expected_grants.push_back(make_grant(b, 1'b1, hits == int'(cnt)));
                end
            end
            if (hits < int'(cnt))
                expected_grants.push_back(make_grant(0, 1'b0, 1'b1));
        end
        else
        begin
            // run search upward, no wrap at the end of the map
            for (int b = int'(addr); b < NUM_BLOCKS && !run_found; b++)
            begin
                if (free_bits[b])
                begin
                    if (run_len == 0)
                        run_start = b;
                    run_len++;
                    run_found = (run_len == int'(cnt));
                end
                else
                    run_len = 0;
            end
            if (run_found)
                expected_grants.push_back(make_grant(run_start, 1'b1, 1'b1));
            else
                expected_grants.push_back(make_grant(0, 1'b0, 1'b1));
        end
    endfunction

    // Present one request word, sender may idle between bursts
    task automatic send_request(input op_t op, input logic [ADDR_W-1:0] addr,
                                input logic [COUNT_W-1:0] cnt, input logic hand_chk,
                                input grant_t hand_grant);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {cnt, addr};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        predict_allocation(op, addr, cnt);
        // typed value stands in for the single predicted word
        if (hand_chk)
        begin
            void'(expected_grants.pop_back());
            expected_grants.push_back(hand_grant);
        end
    endtask

    function automatic logic [COUNT_W-1:0] pick_count(input int pct_bad);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < pct_bad)
            return ($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(MAX_REQUEST + 1, 127));
        else if (sel < 80)
            return 7'($urandom_range(1, 8));
        else
            return 7'($urandom_range(1, MAX_REQUEST));
    endfunction

    // Random request; weights in percent for search free, mark used, mark free
    task automatic send_random(input int w_free, input int w_used, input int w_mfree,
                               input int pct_bad);
        int                  sel;
        op_t                 op;
        logic [ADDR_W-1:0]   addr;
        sel = $urandom_range(0, 99);
        if (sel < w_free)
            op = OP_SEARCH_FREE;
        else if (sel < w_free + w_used)
            op = OP_MARK_USED;
        else if (sel < w_free + w_used + w_mfree)
            op = OP_MARK_FREE;
        else
            op = OP_SEARCH_RUN;
        addr = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 511))
                                            : 9'($urandom_range(0, 63));
        send_request(op, addr, pick_count(pct_bad), 1'b0, '0);
    endtask

    // Receiver: ready density is redrawn each time ready_cyc wraps, mode 0 never stalls
    int ready_mode = 0;
    int ready_cyc  = 0;
    always @(posedge clk)
    begin
        if (ready_cyc == 0)
            ready_mode <= $urandom_range(0, 3);
        ready_cyc <= (ready_cyc + 1) % 256;
        m_tready  <= ($urandom_range(0, 3) >= ready_mode);
    end

    // Result checker
    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_grants.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: blk=%0d found=%0b last=%0b",
                             m_tdata[ADDR_W-1:0], m_tuser, m_tlast);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (m_tdata[ADDR_W-1:0] !== want.blk || m_tuser !== want.found ||
                    m_tlast !== want.last || m_tdata[15:ADDR_W] !== '0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: exp blk=%0d found=%0b last=%0b, ",
                                  "got tdata=%h found=%0b last=%0b"},
                                 want.blk, want.found, want.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("free_block_bitmap_allocator regression: fail");
        $finish;
    end

    // Stimulus
    initial
    begin
        for (int b = 0; b < NUM_BLOCKS; b++)
            free_bits[b] = (b != 0);

        // op, address, count, typed, expected block, expected found
        plan = '{
            '{OP_SEARCH_FREE, 9'd0,   7'd1,   1'b1, 9'd1,   1'b1},  // block 0 taken at reset
            '{OP_SEARCH_RUN,  9'd0,   7'd1,   1'b1, 9'd1,   1'b1},
            '{OP_MARK_USED,   9'd511, 7'd0,   1'b1, 9'd511, 1'b1},
            '{OP_SEARCH_RUN,  9'd505, 7'd7,   1'b1, 9'd0,   1'b0},  // blocked by 511
            '{OP_MARK_FREE,   9'd511, 7'd127, 1'b1, 9'd511, 1'b1},
            '{OP_SEARCH_RUN,  9'd505, 7'd7,   1'b1, 9'd505, 1'b1},
            '{OP_SEARCH_RUN,  9'd511, 7'd1,   1'b1, 9'd511, 1'b1},
            '{OP_SEARCH_RUN,  9'd511, 7'd2,   1'b1, 9'd0,   1'b0},  // runs off the end
            '{OP_SEARCH_FREE, 9'd0,   7'd0,   1'b1, 9'd0,   1'b0},
            '{OP_SEARCH_RUN,  9'd3,   7'd0,   1'b1, 9'd0,   1'b0},
            '{OP_SEARCH_FREE, 9'd0,   7'd65,  1'b1, 9'd0,   1'b0},
            '{OP_SEARCH_RUN,  9'd0,   7'd127, 1'b1, 9'd0,   1'b0},
            '{OP_SEARCH_FREE, 9'd511, 7'd64,  1'b0, 9'd0,   1'b0},
            '{OP_MARK_USED,   9'd0,   7'd1,   1'b1, 9'd0,   1'b1},  // already used
            '{OP_MARK_FREE,   9'd0,   7'd64,  1'b1, 9'd0,   1'b1},
            '{OP_SEARCH_FREE, 9'd0,   7'd3,   1'b0, 9'd0,   1'b0},
            '{OP_MARK_USED,   9'd2,   7'd5,   1'b1, 9'd2,   1'b1},
            '{OP_SEARCH_RUN,  9'd0,   7'd64,  1'b0, 9'd0,   1'b0},
            '{OP_SEARCH_FREE, 9'd0,   7'd4,   1'b0, 9'd0,   1'b0},
            '{OP_MARK_USED,   9'd256, 7'd0,   1'b1, 9'd256, 1'b1},
            '{OP_MARK_USED,   9'd170, 7'd85,  1'b1, 9'd170, 1'b1},
            '{OP_MARK_USED,   9'd341, 7'd42,  1'b1, 9'd341, 1'b1},
            '{OP_SEARCH_RUN,  9'd255, 7'd64,  1'b0, 9'd0,   1'b0},
            '{OP_MARK_FREE,   9'd2,   7'd0,   1'b1, 9'd2,   1'b1},
            '{OP_MARK_FREE,   9'd256, 7'd0,   1'b1, 9'd256, 1'b1}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
            send_request(plan[i].op, plan[i].addr, plan[i].cnt, plan[i].hand_chk,
                         make_grant(int'(plan[i].exp_blk), plan[i].exp_found, 1'b1));

        // mixed traffic on a mostly free map
        repeat (100)
            send_random(30, 25, 15, 6);

        // take out a good part of the map, with searches sprinkled in
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            if (free_bits[b] && $urandom_range(0, 7) < 3)
                send_request(OP_MARK_USED, 9'(b), 7'($urandom_range(0, 127)), 1'b0, '0);
            if ($urandom_range(0, 23) == 0)
                send_random(50, 0, 0, 0);
        end

        // denser map: scans run longer, frees reopen short runs
        repeat (95)
            send_random(35, 20, 25, 4);

        s_tvalid <= 1'b0;
        while (expected_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (expected_grants.size() != 0)
        begin
            fail_count++;
            $display("%0d result words never arrived", expected_grants.size());
        end
        if (fail_count == 0)
            $display("free_block_bitmap_allocator regression: pass");
        else
            $display("free_block_bitmap_allocator regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/fbba_pkg.sv
rtl/core/fbba_ram.sv
rtl/core/fbba_ctrl.sv
rtl/core/fbba_dpath.sv
rtl/core/free_block_bitmap_allocator.sv
verif/testbench.sv
